FILE: rtl/alle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alle_pkg: shared definitions for the array linked list engine
// Sizes, pointer codes, opcode and status codes, and the control bundle that
// the sequencer sends to the link store.
// ----------------------------------------------------------------------------
package alle_pkg;

    // Node store geometry.
    localparam int NODE_COUNT = 16;
    localparam int ELEM_W     = 32;
    localparam int IDX_W      = $clog2(NODE_COUNT);
    // A pointer also holds the null code, one past the last node index.
    localparam int PTR_W      = $clog2(NODE_COUNT + 1);

    // Fixed port widths.
    localparam int OPCODE_W = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 5;

    localparam logic [PTR_W-1:0] NULL_LINK = PTR_W'(NODE_COUNT);

    // Opcodes.
    localparam logic [OPCODE_W-1:0] OP_CLEAR     = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_INS_FRONT = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_INS_BACK  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_REMOVE    = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_QUERY     = 3'd4;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

    // Control bundle from the sequencer to the link store.
    typedef struct packed {
        logic             clear;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [PTR_W-1:0] wr_data;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
    } link_req_t;

    // True when a pointer names a real node.
    function automatic logic is_node(input logic [PTR_W-1:0] ptr);
        return ptr < PTR_W'(NODE_COUNT);
    endfunction

endpackage

FILE: rtl/array_linked_list_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_linked_list_engine_top: singly linked list in a fixed node store
// Sequencer that runs list operations over an element RAM and a link store.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (s_valid, s_ready, s_opcode, s_value) takes one operation
// per transaction: clear, insert at front, insert at back, remove the first
// node equal to s_value, or query. Each operation gives exactly one result
// transaction on the output channel (m_valid, m_ready, m_*): status, first
// and last element, length, and the empty and full flags.
// s_ready is high only while the sequencer is idle; one operation runs at a
// time. Clear, query, a full insert and a remove on an empty list go straight
// to the result step (S_DONE); an insert first passes S_INS, and S_APPEND at
// the back of a non-empty list. A remove walks the list one node per cycle
// through the shared read port of the two node memories and the value
// comparator, then unlinks the matched node in S_UNLINK and, if needed,
// S_RELINK or S_HEAD_LD. s_ready returns in the cycle that m_valid rises.
// The result waits in an output register; while the receiver stalls, the
// next operation can still be accepted and worked, and it holds in its last
// step until the output register frees. A synchronous reset (aresetn low)
// empties the list and rebuilds the free chain at once; no clearing pass.
// ----------------------------------------------------------------------------
module array_linked_list_engine_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [alle_pkg::OPCODE_W-1:0] s_opcode,
    input  logic [alle_pkg::VALUE_W-1:0]  s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [alle_pkg::STATUS_W-1:0] m_status,
    output logic [alle_pkg::VALUE_W-1:0]  m_first_value,
    output logic [alle_pkg::VALUE_W-1:0]  m_last_value,
    output logic [alle_pkg::LEN_W-1:0]    m_length,
    output logic                          m_is_empty,
    output logic                          m_is_full
);
    import alle_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_APPEND,
        S_WALK,
        S_UNLINK,
        S_RELINK,
        S_HEAD_LD,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    // List bookkeeping.
    logic [PTR_W-1:0]    head_reg, head_next;
    logic [PTR_W-1:0]    tail_reg, tail_next;
    logic [PTR_W-1:0]    free_reg, free_next;
    logic [PTR_W-1:0]    count_reg, count_next;
    logic [ELEM_W-1:0]   head_val_reg, head_val_next;
    logic [ELEM_W-1:0]   tail_val_reg, tail_val_next;

    // Operation in progress.
    logic [OPCODE_W-1:0] op_reg, op_next;
    logic [ELEM_W-1:0]   val_reg, val_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [PTR_W-1:0]    node_reg, node_next;
    logic [PTR_W-1:0]    cur_reg, cur_next;
    logic [PTR_W-1:0]    prev_reg, prev_next;
    logic [ELEM_W-1:0]   prev_val_reg, prev_val_next;
    logic [PTR_W-1:0]    nxt_reg, nxt_next;
    logic [PTR_W-1:0]    steps_reg, steps_next;

    // Output register.
    logic                m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0] m_status_reg, m_status_next;
    logic [VALUE_W-1:0]  m_first_reg, m_first_next;
    logic [VALUE_W-1:0]  m_last_reg, m_last_next;
    logic [LEN_W-1:0]    m_length_reg, m_length_next;
    logic                m_empty_reg, m_empty_next;
    logic                m_full_reg, m_full_next;

    // Memory ports.
    link_req_t           link_req;
    logic [PTR_W-1:0]    link_rd;
    logic                elem_wr_en;
    logic [ELEM_W-1:0]   elem_rd;
    logic                match;

    alle_link_store u_link (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (link_req),
        .rd_data (link_rd)
    );

    // Both memories share one read address; the element store is written
    // only when a node is taken from the free chain.
    alle_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (NODE_COUNT)
    ) u_elem (
        .aclk    (aclk),
        .wr_en   (elem_wr_en),
        .wr_addr (free_reg[IDX_W-1:0]),
        .wr_data (val_reg),
        .rd_en   (link_req.rd_en),
        .rd_addr (link_req.rd_addr),
        .rd_data (elem_rd)
    );

    // The shared comparator checks the node just read against the key.
    assign match = (elem_rd == val_reg);

    // Sequencer next-state logic.
    always_comb begin
        state_next    = state_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        free_next     = free_reg;
        count_next    = count_reg;
        head_val_next = head_val_reg;
        tail_val_next = tail_val_reg;
        op_next       = op_reg;
        val_next      = val_reg;
        status_next   = status_reg;
        node_next     = node_reg;
        cur_next      = cur_reg;
        prev_next     = prev_reg;
        prev_val_next = prev_val_reg;
        nxt_next      = nxt_reg;
        steps_next    = steps_reg;
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_first_next  = m_first_reg;
        m_last_next   = m_last_reg;
        m_length_next = m_length_reg;
        m_empty_next  = m_empty_reg;
        m_full_next   = m_full_reg;
        link_req      = '0;
        elem_wr_en    = 1'b0;

        // The receiver took the current result.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next     = s_opcode;
                    val_next    = ELEM_W'(s_value);
                    status_next = ST_DONE;
                    state_next  = S_DONE;
                    unique case (s_opcode) inside
                        OP_CLEAR: begin
                            link_req.clear = 1'b1;
                            head_next      = NULL_LINK;
                            tail_next      = NULL_LINK;
                            free_next      = '0;
                            count_next     = '0;
                        end
                        OP_INS_FRONT, OP_INS_BACK: begin
                            if (!is_node(free_reg)) begin
                                status_next = ST_FULL;
                            end else begin
                                // Fetch the link of the free node to pop it.
                                link_req.rd_en   = 1'b1;
                                link_req.rd_addr = free_reg[IDX_W-1:0];
                                state_next       = S_INS;
                            end
                        end
                        OP_REMOVE: begin
                            if (!is_node(head_reg)) begin
                                status_next = ST_NOT_FOUND;
                            end else begin
                                link_req.rd_en   = 1'b1;
                                link_req.rd_addr = head_reg[IDX_W-1:0];
                                cur_next         = head_reg;
                                prev_next        = NULL_LINK;
                                steps_next       = '0;
                                state_next       = S_WALK;
                            end
                        end
                        default: begin
                            // Query and unused codes leave the list as is.
                        end
                    endcase
                end
            end

            S_INS: begin
                // Pop the free node, store the element and link it in.
                elem_wr_en       = 1'b1;
                free_next        = link_rd;
                count_next       = count_reg + PTR_W'(1);
                node_next        = free_reg;
                link_req.wr_en   = 1'b1;
                link_req.wr_addr = free_reg[IDX_W-1:0];
                state_next       = S_DONE;
                if (op_reg == OP_INS_FRONT) begin
                    link_req.wr_data = head_reg;
                    if (!is_node(head_reg)) begin
                        tail_next     = free_reg;
                        tail_val_next = val_reg;
                    end
                    head_next     = free_reg;
                    head_val_next = val_reg;
                end else begin
                    link_req.wr_data = NULL_LINK;
                    if (is_node(tail_reg)) begin
                        state_next = S_APPEND;
                    end else begin
                        head_next     = free_reg;
                        head_val_next = val_reg;
                        tail_next     = free_reg;
                        tail_val_next = val_reg;
                    end
                end
            end

            S_APPEND: begin
                // Hang the new node after the old tail.
                link_req.wr_en   = 1'b1;
                link_req.wr_addr = tail_reg[IDX_W-1:0];
                link_req.wr_data = node_reg;
                tail_next        = node_reg;
                tail_val_next    = val_reg;
                state_next       = S_DONE;
            end

            S_WALK: begin
                // One node per cycle: compare, then follow the link.
                if (steps_reg >= PTR_W'(NODE_COUNT)) begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_DONE;
                end else if (match) begin
                    nxt_next   = link_rd;
                    state_next = S_UNLINK;
                end else if (!is_node(link_rd)) begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_DONE;
                end else begin
                    prev_next        = cur_reg;
                    prev_val_next    = elem_rd;
                    cur_next         = link_rd;
                    steps_next       = steps_reg + PTR_W'(1);
                    link_req.rd_en   = 1'b1;
                    link_req.rd_addr = link_rd[IDX_W-1:0];
                end
            end

            S_UNLINK: begin
                // Return the matched node to the head of the free chain.
                link_req.wr_en   = 1'b1;
                link_req.wr_addr = cur_reg[IDX_W-1:0];
                link_req.wr_data = free_reg;
                free_next        = cur_reg;
                if (count_reg != '0) begin
                    count_next = count_reg - PTR_W'(1);
                end
                if (tail_reg == cur_reg) begin
                    tail_next     = prev_reg;
                    tail_val_next = prev_val_reg;
                end
                if (is_node(prev_reg)) begin
                    state_next = S_RELINK;
                end else begin
                    head_next = nxt_reg;
                    if (is_node(nxt_reg)) begin
                        // The new head's element must be fetched.
                        link_req.rd_en   = 1'b1;
                        link_req.rd_addr = nxt_reg[IDX_W-1:0];
                        state_next       = S_HEAD_LD;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end

            S_RELINK: begin
                link_req.wr_en   = 1'b1;
                link_req.wr_addr = prev_reg[IDX_W-1:0];
                link_req.wr_data = nxt_reg;
                state_next       = S_DONE;
            end

            S_HEAD_LD: begin
                head_val_next = elem_rd;
                state_next    = S_DONE;
            end

            S_DONE: begin
                // Load the result once the output register is free.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_first_next  = is_node(head_reg) ? VALUE_W'(head_val_reg) : '0;
                    m_last_next   = is_node(tail_reg) ? VALUE_W'(tail_val_reg) : '0;
                    m_length_next = LEN_W'(count_reg);
                    m_empty_next  = !is_node(head_reg);
                    m_full_next   = !is_node(free_reg);
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, list pointers and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= NULL_LINK;
            tail_reg    <= NULL_LINK;
            free_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            free_reg    <= free_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        head_val_reg  <= head_val_next;
        tail_val_reg  <= tail_val_next;
        op_reg        <= op_next;
        val_reg       <= val_next;
        status_reg    <= status_next;
        node_reg      <= node_next;
        cur_reg       <= cur_next;
        prev_reg      <= prev_next;
        prev_val_reg  <= prev_val_next;
        nxt_reg       <= nxt_next;
        steps_reg     <= steps_next;
        m_status_reg  <= m_status_next;
        m_first_reg   <= m_first_next;
        m_last_reg    <= m_last_next;
        m_length_reg  <= m_length_next;
        m_empty_reg   <= m_empty_next;
        m_full_reg    <= m_full_next;
    end

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_first_value = m_first_reg;
    assign m_last_value  = m_last_reg;
    assign m_length      = m_length_reg;
    assign m_is_empty    = m_empty_reg;
    assign m_is_full     = m_full_reg;

endmodule

FILE: rtl/alle_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alle_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module alle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/alle_link_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alle_link_store: node link memory with per-entry valid bits
// An entry that has not been written since reset or the last clear reads as
// its rebuilt value, a link to the next node, or null for the last node.
// ----------------------------------------------------------------------------
module alle_link_store (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  alle_pkg::link_req_t       req,
    output logic [alle_pkg::PTR_W-1:0] rd_data
);
    import alle_pkg::*;

    logic [PTR_W-1:0]      ram_rd_data;
    logic [NODE_COUNT-1:0] valid_reg;
    logic                  rd_valid_reg;
    logic [IDX_W-1:0]      rd_addr_reg;

    alle_ram #(
        .WIDTH (PTR_W),
        .DEPTH (NODE_COUNT)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (req.wr_en),
        .wr_addr (req.wr_addr),
        .wr_data (req.wr_data),
        .rd_en   (req.rd_en),
        .rd_addr (req.rd_addr),
        .rd_data (ram_rd_data)
    );

    // Valid bits: a write marks an entry, a clear drops them all at once.
    always_ff @(posedge aclk) begin
        if (!aresetn || req.clear) begin
            valid_reg <= '0;
        end else if (req.wr_en) begin
            valid_reg[req.wr_addr] <= 1'b1;
        end
    end

    // Track the valid bit and address of the read in flight.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else if (req.rd_en) begin
            rd_valid_reg <= valid_reg[req.rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_addr_reg <= req.rd_addr;
        end
    end

    // The rebuilt link of node i is i + 1, which is null for the last node.
    assign rd_data = rd_valid_reg ? ram_rd_data
                                  : PTR_W'(rd_addr_reg) + PTR_W'(1);

endmodule

FILE: rtl/alle_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alle_checker: port-level checks for the array linked list engine
// Watches the top-level ports and flags inconsistent results.
// ----------------------------------------------------------------------------
module alle_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [alle_pkg::STATUS_W-1:0] m_status,
    input logic [alle_pkg::VALUE_W-1:0]  m_first_value,
    input logic [alle_pkg::VALUE_W-1:0]  m_last_value,
    input logic [alle_pkg::LEN_W-1:0]    m_length,
    input logic                          m_is_empty,
    input logic                          m_is_full
);
    import alle_pkg::*;

    // An empty list reports zero length and zero end values.
    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_empty |-> m_length == '0 && m_first_value == '0
                                  && m_last_value == '0)
        else $error("empty result with nonzero length or values");

    // A non-empty list never reports zero length or more than the store holds.
    a_length_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_is_empty |-> m_length != '0
                                   && m_length <= LEN_W'(NODE_COUNT))
        else $error("length out of range for a non-empty list");

    // A refused insert must come with the full flag.
    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_FULL |-> m_is_full)
        else $error("full status without full flag");

    // Only one operation is worked at a time.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready right after accepting an operation");

    // A stalled result holds m_valid, status, first value and length.
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status)
                                && $stable(m_first_value) && $stable(m_length))
        else $error("result changed while stalled");

endmodule

bind array_linked_list_engine_top alle_checker u_alle_checker (.*);
